// ----- sv/mlprq_pkg.sv -----
// Shared types, sizes and codes of the multilevel priority ready queue.
package mlprq_pkg;

   // Storage sizes.
   localparam int LEVELS  = 64;
   localparam int ENTRIES = 64;
   localparam int LEVEL_W = $clog2(LEVELS);
   localparam int ENTRY_W = $clog2(ENTRIES);

   // Word field widths.
   localparam int KIND_W = 2;
   localparam int ID_W   = 6;
   localparam int PRI_W  = 6;

   // The top-level search runs over groups of eight levels.
   localparam int GROUP_SIZE  = 8;
   localparam int GROUP_IDX_W = 3;
   localparam int NGROUPS     = (LEVELS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_W       = NGROUPS * GROUP_SIZE;

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   entry_id;
      logic [PRI_W-1:0]  priority_req;
   } mlprq_req_type;

   typedef struct packed {
      logic [ID_W-1:0]  popped_id;
      logic             popped_valid;
      logic             queue_empty;
      logic [PRI_W-1:0] top_priority;
      logic             insert_rejected;
   } mlprq_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_LEVEL,
      ST_READ_LINK,
      ST_UPDATE,
      ST_SCAN,
      ST_MERGE,
      ST_REPLY
   } mlprq_state_type;

   typedef struct packed {
      logic capture;
      logic read_level;
      logic read_link;
      logic update;
      logic scan;
      logic merge;
      logic reply;
   } mlprq_cmd_type;

   typedef struct packed {
      logic changes;
      logic pop;
   } mlprq_stat_type;

endpackage

// ----- sv/multilevel_priority_ready_queue_unit.sv -----
// Top level of the multilevel priority ready queue: sequencer, datapath and result register.
//
// This unit keeps one FIFO of entry ids for each priority level and takes one request
// word at a time on the req_ channel: insert an id at a level, pop the oldest id of the
// highest busy level, or peek. Every request yields exactly one word on the rsp_ channel
// with the popped id, whether the queue is now empty, the highest busy level and whether
// an insert was refused because the id was already queued. An insert passes the states
// READ_LEVEL, UPDATE, SCAN and MERGE before REPLY; a pop that finds an entry also passes
// READ_LINK after READ_LEVEL; a peek, a refused insert or a pop of an empty queue goes
// from READ_LEVEL straight to REPLY, and REPLY waits while the result register is held
// by the consumer. The single-ported list memories are read and then written in turn (a
// pop also follows the link of the head id). After each change the highest busy level is searched anew.
// Result words are held in an output register, so a finished word waits there while
// the next request is already being worked on. There is no clearing pass after reset:
// an insert into an empty level and a pop of the last id of a level may read list
// memory entries that were never written, but those values are never used.
module multilevel_priority_ready_queue_unit
   import mlprq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  mlprq_req_type req_word,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output mlprq_rsp_type rsp_word
);

   mlprq_cmd_type  cmd;
   mlprq_stat_type stat;
   mlprq_rsp_type  result;
   mlprq_rsp_type  rsp_word_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           slot_free;

   // The result register can take a new word when it is empty or being drained now.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   mlprq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .slot_free (slot_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   mlprq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.reply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- sv/mlprq_ctrl.sv -----
// Operation sequencer of the multilevel priority ready queue.
module mlprq_ctrl
   import mlprq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           slot_free,
   input  mlprq_stat_type stat,
   output mlprq_cmd_type  cmd
);

   mlprq_state_type state_ff;
   mlprq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ_LEVEL;
            end
         end
         ST_READ_LEVEL: begin
            if (!stat.changes) begin
               state_in = ST_REPLY;
            end else if (stat.pop) begin
               state_in = ST_READ_LINK;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_READ_LINK: state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_SCAN;
         ST_SCAN:      state_in = ST_MERGE;
         ST_MERGE:     state_in = ST_REPLY;
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_READ_LEVEL: cmd.read_level = 1'b1;
         ST_READ_LINK:  cmd.read_link  = 1'b1;
         ST_UPDATE:     cmd.update     = 1'b1;
         ST_SCAN:       cmd.scan       = 1'b1;
         ST_MERGE:      cmd.merge      = 1'b1;
         ST_REPLY:      cmd.reply      = slot_free;
         default:       req_stall      = 1'b1;
      endcase
   end

endmodule

// ----- sv/mlprq_dpath.sv -----
// Datapath of the multilevel priority ready queue: list memories, bitmaps and level search.
module mlprq_dpath
   import mlprq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  mlprq_req_type  req_word,
   input  mlprq_cmd_type  cmd,
   output mlprq_stat_type stat,
   output mlprq_rsp_type  result
);

   // Per-level head and tail ids and per-id successor links.
   logic [ENTRY_W-1:0] mem_first [LEVELS];
   logic [ENTRY_W-1:0] mem_last  [LEVELS];
   logic [ENTRY_W-1:0] mem_link  [ENTRIES];

   logic [LEVELS-1:0]  nonempty_ff;
   logic [ENTRIES-1:0] queued_ff;
   logic [LEVEL_W-1:0] top_lvl_ff;
   logic               empty_ff;

   logic               insert_ff;
   logic               pop_ff;
   logic               reject_ff;
   logic [ENTRY_W-1:0] op_id_ff;
   logic [LEVEL_W-1:0] op_lvl_ff;

   logic [ENTRY_W-1:0] first_rd_ff;
   logic [ENTRY_W-1:0] last_rd_ff;
   logic [ENTRY_W-1:0] link_rd_ff;

   logic                   grp_any_ff [NGROUPS];
   logic [GROUP_IDX_W-1:0] grp_idx_ff [NGROUPS];
   logic                   grp_any_in [NGROUPS];
   logic [GROUP_IDX_W-1:0] grp_idx_in [NGROUPS];

   logic               cap_insert;
   logic               cap_pop;
   logic               id_bad;
   logic [LEVEL_W-1:0] clamp_lvl;
   logic               lvl_busy;
   logic               pop_last;
   logic               first_we;
   logic [ENTRY_W-1:0] first_wdata;
   logic               last_we;
   logic               link_we;
   logic [PAD_W-1:0]   pad_busy;
   logic [LEVEL_W-1:0] top_lvl_in;
   logic               empty_in;

   // Decode of the incoming word.
   always_comb begin
      cap_insert = 1'b0;
      cap_pop    = 1'b0;
      case (req_word.kind)
         KIND_INSERT: cap_insert = 1'b1;
         KIND_POP:    cap_pop    = 1'b1;
         KIND_PEEK:   cap_insert = 1'b0;
         default:     cap_pop    = 1'b0;
      endcase
   end

   assign id_bad = (32'(req_word.entry_id) >= ENTRIES)
                || queued_ff[ENTRY_W'(req_word.entry_id)];
   assign clamp_lvl = (32'(req_word.priority_req) >= LEVELS) ? LEVEL_W'(LEVELS - 1)
                                                              : LEVEL_W'(req_word.priority_req);

   always_ff @(posedge clock) begin
      if (reset) begin
         insert_ff <= 1'b0;
         pop_ff    <= 1'b0;
         reject_ff <= 1'b0;
      end else if (cmd.capture) begin
         insert_ff <= cap_insert && !id_bad;
         reject_ff <= cap_insert && id_bad;
         pop_ff    <= cap_pop && !empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_id_ff  <= ENTRY_W'(req_word.entry_id);
         op_lvl_ff <= cap_insert ? clamp_lvl : top_lvl_ff;
      end
   end

   assign stat.changes = insert_ff || pop_ff;
   assign stat.pop     = pop_ff;

   assign lvl_busy    = nonempty_ff[op_lvl_ff];
   assign pop_last    = (last_rd_ff == first_rd_ff);
   assign first_we    = cmd.update && ((insert_ff && !lvl_busy) || (pop_ff && !pop_last));
   assign first_wdata = insert_ff ? op_id_ff : link_rd_ff;
   assign last_we     = cmd.update && insert_ff;
   assign link_we     = cmd.update && insert_ff && lvl_busy;

   always_ff @(posedge clock) begin
      if (cmd.read_level) begin
         first_rd_ff <= mem_first[op_lvl_ff];
      end
      if (first_we) begin
         mem_first[op_lvl_ff] <= first_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_level) begin
         last_rd_ff <= mem_last[op_lvl_ff];
      end
      if (last_we) begin
         mem_last[op_lvl_ff] <= op_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_link) begin
         link_rd_ff <= mem_link[first_rd_ff];
      end
      if (link_we) begin
         mem_link[last_rd_ff] <= op_id_ff;
      end
   end

   // Occupancy bitmaps.
   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         queued_ff   <= '0;
      end else if (cmd.update) begin
         if (insert_ff) begin
            nonempty_ff[op_lvl_ff] <= 1'b1;
            queued_ff[op_id_ff]    <= 1'b1;
         end else if (pop_ff) begin
            if (pop_last) begin
               nonempty_ff[op_lvl_ff] <= 1'b0;
            end
            queued_ff[first_rd_ff] <= 1'b0;
         end
      end
   end

   // Highest busy level, first within each group of eight, then across groups.
   assign pad_busy = PAD_W'(nonempty_ff);

   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (pad_busy[g * GROUP_SIZE + j]) begin
               grp_any_in[g] = 1'b1;
               grp_idx_in[g] = GROUP_IDX_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         for (int g = 0; g < NGROUPS; g++) begin
            grp_any_ff[g] <= grp_any_in[g];
            grp_idx_ff[g] <= grp_idx_in[g];
         end
      end
   end

   always_comb begin
      top_lvl_in = '0;
      empty_in   = 1'b1;
      for (int g = 0; g < NGROUPS; g++) begin
         if (grp_any_ff[g]) begin
            empty_in   = 1'b0;
            top_lvl_in = LEVEL_W'(g * GROUP_SIZE + int'(grp_idx_ff[g]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_lvl_ff <= '0;
         empty_ff   <= 1'b1;
      end else if (cmd.merge) begin
         top_lvl_ff <= top_lvl_in;
         empty_ff   <= empty_in;
      end
   end

   assign result.popped_id       = pop_ff ? ID_W'(first_rd_ff) : '0;
   assign result.popped_valid    = pop_ff;
   assign result.queue_empty     = empty_ff;
   assign result.top_priority    = empty_ff ? '0 : PRI_W'(top_lvl_ff);
   assign result.insert_rejected = reject_ff;

   // Every busy level holds at least one queued id.
   a_ids_cover_levels: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_ff) >= $countones(nonempty_ff))
      else $error("more busy levels than queued ids");

   // The empty flag agrees with the bitmap once the search has finished.
   a_empty_matches: assert property (@(posedge clock) disable iff (reset)
      cmd.merge |=> (empty_ff == (nonempty_ff == '0)))
      else $error("empty flag disagrees with level bitmap");

   // An accepted insert leaves its id queued and its level busy.
   a_insert_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && insert_ff) |=> (queued_ff[op_id_ff] && nonempty_ff[op_lvl_ff]))
      else $error("insert did not mark id and level");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the multilevel priority ready queue unit.
//
// The bench keeps its own copy of the ready queue: one FIFO of ids per priority level
// and a flag per id that says whether it is queued. Every request word that the unit
// accepts is run through that copy, and the status word it yields is put on a list of
// words still owed by the unit. Every word the unit hands over is compared field by
// field with the oldest owed word.
//
// Stimulus starts with a short directed sequence and then runs random phases. The
// directed part covers an empty queue, the lowest and highest ids and levels, a refused
// duplicate, FIFO order inside one level, a re-insert after a pop, and the unused kind
// code. The random phases lean toward filling, draining, balanced traffic, or traffic
// crowded onto a few levels, so that the queue both runs deep and empties often.
//
// Both sides pause at random. Twice the consumer also holds the result channel off for
// a long stretch, which lets the output register fill and the unit stall its input.
module tb;
   import mlprq_pkg::*;

   // The fourth kind code has no name in the package; the unit treats it as a peek.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 1600;
   localparam int HOLD_CYCLES  = 250;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   mlprq_req_type req_word = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   mlprq_rsp_type rsp_word;

   multilevel_priority_ready_queue_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   // Shadow copy of the ready queue.
   logic [ID_W-1:0] level_list [LEVELS][$];
   logic            id_busy [ENTRIES];

   // Request words waiting to be sent, and status words the unit still owes.
   mlprq_req_type op_backlog [$];
   mlprq_rsp_type status_due [$];

   int total_words    = 0;
   int accepted_count = 0;
   int issued_count   = 0;
   int rsp_count      = 0;
   int error_count    = 0;

   // Figures for the closing summary.
   int n_insert   = 0;
   int n_refused  = 0;
   int n_pop_hit  = 0;
   int n_pop_miss = 0;
   int n_peek     = 0;
   int n_depth    = 0;
   int deepest    = 0;

   // Applies one request to the shadow queue and returns the status word it causes.
   function automatic mlprq_rsp_type apply_queue_op(mlprq_req_type w);
      mlprq_rsp_type s;
      int            lv;
      int            top;
      s = '0;
      if (w.kind == KIND_INSERT) begin
         n_insert++;
         // A six-bit id and level always fall inside the 64 ids and 64 levels,
         // so the only refusal left is an id that is already queued.
         if (id_busy[w.entry_id]) begin
            s.insert_rejected = 1'b1;
            n_refused++;
         end else begin
            level_list[w.priority_req].push_back(w.entry_id);
            id_busy[w.entry_id] = 1'b1;
            n_depth++;
            if (n_depth > deepest) deepest = n_depth;
         end
      end else if (w.kind == KIND_POP) begin
         top = -1;
         for (lv = LEVELS - 1; lv >= 0 && top < 0; lv--)
            if (level_list[lv].size() != 0) top = lv;
         if (top >= 0) begin
            s.popped_id    = level_list[top].pop_front();
            s.popped_valid = 1'b1;
            id_busy[s.popped_id] = 1'b0;
            n_depth--;
            n_pop_hit++;
         end else begin
            n_pop_miss++;
         end
      end else begin
         // Peek and the unused code leave the queue alone.
         n_peek++;
      end
      // Status after the operation: highest busy level, or empty.
      top = -1;
      for (lv = LEVELS - 1; lv >= 0 && top < 0; lv--)
         if (level_list[lv].size() != 0) top = lv;
      s.queue_empty  = (top < 0);
      s.top_priority = (top < 0) ? '0 : top[PRI_W-1:0];
      return s;
   endfunction

   function automatic mlprq_req_type make_op(logic [KIND_W-1:0] k, int id, int pri);
      mlprq_req_type w;
      w.kind         = k;
      w.entry_id     = id[ID_W-1:0];
      w.priority_req = pri[PRI_W-1:0];
      return w;
   endfunction

   // Length of the next pause: mostly none or short, now and then long. A side can
   // also enter a calm spell in which it does not pause at all for a while.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(30, 90);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sender. A word stays on the port until the count of accepted words catches up
   // with the count of issued words; then the next one goes out, possibly after a gap.
   int send_gap  = 0;
   int send_calm = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && accepted_count != issued_count)) begin
         if (req_valid) send_gap = pick_gap(send_calm);
         if (send_gap > 0 || op_backlog.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            req_word  <= op_backlog.pop_front();
            req_valid <= 1'b1;
            issued_count++;
         end
      end
   end

   // Consumer stall. Besides the random pauses, the result channel is held off for a
   // long stretch twice while plenty of requests are still queued up on the sender.
   int recv_gap   = 0;
   int recv_calm  = 0;
   int hold_left  = 0;
   int hold_stage = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0 && hold_stage < 2 &&
             rsp_count >= ((hold_stage == 0) ? 400 : 1100)) begin
            hold_left = HOLD_CYCLES;
            hold_stage++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (recv_gap > 0) begin
            rsp_stall <= 1'b1;
            recv_gap--;
         end else begin
            rsp_stall <= 1'b0;
            recv_gap = ($urandom_range(0, 2) == 0) ? pick_gap(recv_calm) : 0;
         end
      end
   end

   // Checker. A status word handed over at this edge always belongs to a request taken
   // at an earlier edge, so it is checked before this edge's request is predicted.
   always @(posedge clock) begin
      mlprq_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (status_due.size() == 0) begin
               $error("status word with no request outstanding: %p", rsp_word);
               error_count++;
            end else begin
               want = status_due.pop_front();
               if (rsp_word.popped_id !== want.popped_id) begin
                  $error("popped_id expected %0d got %0d", want.popped_id,
                         rsp_word.popped_id);
                  error_count++;
               end
               if (rsp_word.popped_valid !== want.popped_valid) begin
                  $error("popped_valid expected %0d got %0d", want.popped_valid,
                         rsp_word.popped_valid);
                  error_count++;
               end
               if (rsp_word.queue_empty !== want.queue_empty) begin
                  $error("queue_empty expected %0d got %0d", want.queue_empty,
                         rsp_word.queue_empty);
                  error_count++;
               end
               if (rsp_word.top_priority !== want.top_priority) begin
                  $error("top_priority expected %0d got %0d", want.top_priority,
                         rsp_word.top_priority);
                  error_count++;
               end
               if (rsp_word.insert_rejected !== want.insert_rejected) begin
                  $error("insert_rejected expected %0d got %0d", want.insert_rejected,
                         rsp_word.insert_rejected);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            status_due.push_back(apply_queue_op(req_word));
            accepted_count++;
         end
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin
      int               i;
      int               r;
      int               phase;
      int               pri;
      logic [KIND_W-1:0] k;

      for (i = 0; i < ENTRIES; i++) id_busy[i] = 1'b0;

      // Directed opening: empty queue first, then the extremes of id and level, a
      // refused duplicate, FIFO order within the top level, a re-insert of a popped
      // id, and a drain down to empty again.
      op_backlog.push_back(make_op(KIND_PEEK,   0, 0));
      op_backlog.push_back(make_op(KIND_POP,   63, 63));
      op_backlog.push_back(make_op(KIND_UNUSED, 63, 63));
      op_backlog.push_back(make_op(KIND_INSERT, 0, 0));
      op_backlog.push_back(make_op(KIND_INSERT, 63, 63));
      op_backlog.push_back(make_op(KIND_INSERT, 63, 5));
      op_backlog.push_back(make_op(KIND_INSERT, 0, 63));
      op_backlog.push_back(make_op(KIND_INSERT, 42, 63));
      op_backlog.push_back(make_op(KIND_INSERT, 21, 63));
      op_backlog.push_back(make_op(KIND_INSERT, 7, 0));
      op_backlog.push_back(make_op(KIND_INSERT, 45, 42));
      op_backlog.push_back(make_op(KIND_PEEK,  21, 42));
      op_backlog.push_back(make_op(KIND_UNUSED, 42, 21));
      op_backlog.push_back(make_op(KIND_POP,    0, 0));
      op_backlog.push_back(make_op(KIND_POP,    0, 0));
      op_backlog.push_back(make_op(KIND_INSERT, 63, 0));
      op_backlog.push_back(make_op(KIND_POP,    0, 0));
      op_backlog.push_back(make_op(KIND_POP,    0, 0));
      op_backlog.push_back(make_op(KIND_POP,    0, 0));
      op_backlog.push_back(make_op(KIND_POP,    0, 0));
      op_backlog.push_back(make_op(KIND_POP,    0, 0));
      op_backlog.push_back(make_op(KIND_POP,    0, 0));
      op_backlog.push_back(make_op(KIND_PEEK,   0, 0));

      // Random phases of a hundred words each. Ids cover the whole range, so as the
      // queue fills, duplicates turn up on their own. The crowded phase packs ids onto
      // four levels to build long chains inside one level.
      phase = 0;
      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 100 == 0) phase = $urandom_range(0, 3);
         r = $urandom_range(0, 99);
         case (phase)
            0:       k = (r < 70) ? KIND_INSERT : (r < 90) ? KIND_POP : KIND_PEEK;
            1:       k = (r < 22) ? KIND_INSERT : (r < 92) ? KIND_POP : KIND_PEEK;
            2:       k = (r < 47) ? KIND_INSERT : (r < 90) ? KIND_POP : KIND_PEEK;
            default: k = (r < 55) ? KIND_INSERT : (r < 92) ? KIND_POP : KIND_PEEK;
         endcase
         if (k == KIND_PEEK && $urandom_range(0, 2) == 0) k = KIND_UNUSED;
         if (phase == 3 || $urandom_range(0, 3) == 0)
            pri = $urandom_range(0, 3) * 21;
         else
            pri = $urandom_range(0, 63);
         op_backlog.push_back(make_op(k, $urandom_range(0, 63), pri));
      end
      total_words = op_backlog.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < total_words || status_due.size() != 0)
         @(posedge clock);
      // Let a stray extra word show up if the unit were to produce one.
      repeat (16) @(posedge clock);

      $display("Covered %0d requests: %0d inserts (%0d refused), %0d pops, %0d on empty.",
               total_words, n_insert, n_refused, n_pop_hit + n_pop_miss, n_pop_miss);
      $display("Peeks and unused codes: %0d; deepest queue held %0d ids.", n_peek, deepest);
      if (error_count == 0) begin
         $display("PASS multilevel_priority_ready_queue_unit");
      end else begin
         $display("FAIL multilevel_priority_ready_queue_unit");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, even with every pause at its longest.
   initial begin
      #(8 * 1500000);
      $display("FAIL multilevel_priority_ready_queue_unit");
      $finish;
   end

endmodule
